// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file nlr_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent, checked out of reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// expression must never hold out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

// ===== hdl/nlr_pkg.sv =====
// shared widths, register indexes, light tables and link types
// for the normal lighting rgb332 unit; no dependencies
package nlr_pkg;

	localparam int TrigW       = 18;
	localparam int CompW       = 26;
	localparam int DotW        = CompW + TrigW - 16;
	localparam int MagW        = 26;
	localparam int ColKW       = 24;
	localparam int ContW       = ColKW + MagW - 32;
	localparam int SumW        = 20;
	localparam int LightSets   = 4;
	localparam int LampsPerSet = 3;
	localparam int Axes        = 3;
	localparam int Latency     = 11;

	localparam logic [2:0] REG_ROLL_SIN  = 3'd0;
	localparam logic [2:0] REG_ROLL_COS  = 3'd1;
	localparam logic [2:0] REG_PITCH_SIN = 3'd2;
	localparam logic [2:0] REG_PITCH_COS = 3'd3;
	localparam logic [2:0] REG_YAW_SIN   = 3'd4;
	localparam logic [2:0] REG_YAW_COS   = 3'd5;
	localparam logic [2:0] REG_LIGHT_SET = 3'd6;

	localparam logic signed [TrigW-1:0] TrigOne = 18'sd65536;

	typedef struct packed {
		logic [TrigW-1:0] s;
		logic [TrigW-1:0] c;
	} trig_t;

	typedef struct packed {
		logic             vld;
		logic [CompW-1:0] u;
		logic [CompW-1:0] v;
		logic [CompW-1:0] w;
	} rot_item_t;

	typedef struct packed {
		logic            vld;
		logic [SumW-1:0] r;
		logic [SumW-1:0] g;
		logic [SumW-1:0] b;
	} rgb_sum_t;

	// light directions, unused slots are zero and never light anything
	localparam logic signed [TrigW-1:0] LampDir [LightSets][LampsPerSet][Axes] = '{
		'{ '{  18'sd46340,       18'sd0, 18'sd46340 },
		   '{ -18'sd46340,       18'sd0, 18'sd46333 },
		   '{       18'sd0,      18'sd0,     18'sd0 } },
		'{ '{       18'sd0,      18'sd0, 18'sd65536 },
		   '{  18'sd46340,       18'sd0, 18'sd46340 },
		   '{ -18'sd46340,       18'sd0, 18'sd46333 } },
		'{ '{       18'sd0, -18'sd32768, 18'sd56754 },
		   '{ -18'sd46340,       18'sd0, 18'sd46333 },
		   '{  18'sd46340,       18'sd0, 18'sd46340 } },
		'{ '{       18'sd0,  18'sd46340, 18'sd46340 },
		   '{       18'sd0,      18'sd0,     18'sd0 },
		   '{       18'sd0,      18'sd0,     18'sd0 } }
	};

	localparam logic [16:0] LampCol [LightSets][LampsPerSet][Axes] = '{
		'{ '{ 17'd52428, 17'd52428, 17'd39321 },
		   '{ 17'd39321, 17'd39321, 17'd52428 },
		   '{     17'd0,     17'd0,     17'd0 } },
		'{ '{  17'd6553,  17'd6553,  17'd6553 },
		   '{ 17'd52428,     17'd0, 17'd13107 },
		   '{ 17'd13107,     17'd0, 17'd65536 } },
		'{ '{ 17'd65536,     17'd0,     17'd0 },
		   '{     17'd0, 17'd49152,     17'd0 },
		   '{     17'd0,     17'd0, 17'd65536 } },
		'{ '{ 17'd16384,  17'd6553, 17'd65536 },
		   '{     17'd0,     17'd0,     17'd0 },
		   '{     17'd0,     17'd0,     17'd0 } }
	};

endpackage

// ===== hdl/nlr_rot.sv =====
// one plane rotation of a three component vector, two register stages
// depends on nlr_pkg
module nlr_rot (
	input  logic              clk,
	input  logic              arst_n,
	input  nlr_pkg::trig_t    trig,
	input  nlr_pkg::rot_item_t in_item,
	output nlr_pkg::rot_item_t out_item
);

	localparam int ProdW = nlr_pkg::CompW + nlr_pkg::TrigW + 1;
	localparam int QW    = ProdW - 16;

	logic signed [nlr_pkg::TrigW:0]   cos_e;
	logic signed [nlr_pkg::TrigW:0]   sin_e;
	logic signed [nlr_pkg::TrigW:0]   nsin_e;
	logic signed [ProdW-1:0]          uc;
	logic signed [ProdW-1:0]          vs;
	logic signed [ProdW-1:0]          us;
	logic signed [ProdW-1:0]          vc;
	logic signed [QW-1:0]             uc_s1;
	logic signed [QW-1:0]             vs_s1;
	logic signed [QW-1:0]             us_s1;
	logic signed [QW-1:0]             vc_s1;
	logic [nlr_pkg::CompW-1:0]        w_s1;
	logic                             vld_s1;
	logic signed [QW:0]               su;
	logic signed [QW:0]               sv;
	logic [nlr_pkg::CompW-1:0]        u_s2;
	logic [nlr_pkg::CompW-1:0]        v_s2;
	logic [nlr_pkg::CompW-1:0]        w_s2;
	logic                             vld_s2;

	assign cos_e  = $signed({trig.c[nlr_pkg::TrigW-1], trig.c});
	assign sin_e  = $signed({trig.s[nlr_pkg::TrigW-1], trig.s});
	assign nsin_e = -sin_e;

	assign uc = $signed(in_item.u) * cos_e;
	assign vs = $signed(in_item.v) * nsin_e;
	assign us = $signed(in_item.u) * sin_e;
	assign vc = $signed(in_item.v) * cos_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_item.vld;
			vld_s2 <= vld_s1;
		end
	end

	// floor of product over 2^16 is the upper part of the full product
	always_ff @(posedge clk) begin
		uc_s1 <= uc[ProdW-1:16];
		vs_s1 <= vs[ProdW-1:16];
		us_s1 <= us[ProdW-1:16];
		vc_s1 <= vc[ProdW-1:16];
		w_s1  <= in_item.w;
	end

	assign su = (QW+1)'(uc_s1) + (QW+1)'(vs_s1);
	assign sv = (QW+1)'(us_s1) + (QW+1)'(vc_s1);

	always_ff @(posedge clk) begin
		u_s2 <= su[nlr_pkg::CompW-1:0];
		v_s2 <= sv[nlr_pkg::CompW-1:0];
		w_s2 <= w_s1;
	end

	assign out_item = '{vld: vld_s2, u: u_s2, v: v_s2, w: w_s2};

endmodule

// ===== hdl/nlr_light.sv =====
// per light dot product, facing test, color scaling and channel sums
// four register stages; depends on nlr_pkg
module nlr_light (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         light_set,
	input  nlr_pkg::rot_item_t in_item,
	output nlr_pkg::rgb_sum_t  out_sum
);

	localparam int DProdW = nlr_pkg::CompW + nlr_pkg::TrigW;
	localparam int CProdW = nlr_pkg::ColKW + nlr_pkg::MagW;
	localparam int NL     = nlr_pkg::LampsPerSet;
	localparam int NA     = nlr_pkg::Axes;

	logic signed [nlr_pkg::CompW-1:0] comp [NA];
	logic signed [DProdW-1:0]         dprod [NL][NA];
	logic signed [nlr_pkg::DotW-1:0]  dp_s1 [NL][NA];
	logic                             vld_s1;
	logic signed [nlr_pkg::DotW-1:0]  dot [NL];
	logic signed [nlr_pkg::DotW-1:0]  ndot [NL];
	logic [nlr_pkg::MagW-1:0]         mag_s2 [NL];
	logic                             neg_s2 [NL];
	logic                             vld_s2;
	logic [nlr_pkg::ColKW-1:0]        kcol [NL][NA];
	logic [CProdW-1:0]                cprod [NL][NA];
	logic [nlr_pkg::ContW-1:0]        cont_s3 [NL][NA];
	logic                             vld_s3;
	logic [nlr_pkg::SumW-1:0]         csum [NA];
	logic [nlr_pkg::SumW-1:0]         sum_s4 [NA];
	logic                             vld_s4;

	assign comp[0] = $signed(in_item.u);
	assign comp[1] = $signed(in_item.v);
	assign comp[2] = $signed(in_item.w);

	always_comb begin
		for (int j = 0; j < NL; j++) begin
			for (int a = 0; a < NA; a++) begin
				dprod[j][a] = comp[a] * nlr_pkg::LampDir[light_set][j][a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_item.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NL; j++) begin
			for (int a = 0; a < NA; a++) begin
				dp_s1[j][a] <= dprod[j][a][DProdW-1:16];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < NL; j++) begin
			dot[j]  = dp_s1[j][0] + dp_s1[j][1] + dp_s1[j][2];
			ndot[j] = -dot[j];
		end
	end

	// only lights facing away from the normal contribute
	always_ff @(posedge clk) begin
		for (int j = 0; j < NL; j++) begin
			neg_s2[j] <= dot[j][nlr_pkg::DotW-1];
			mag_s2[j] <= ndot[j][nlr_pkg::MagW-1:0];
		end
	end

	// color times 255 times magnitude, integer part of the Q32 result
	always_comb begin
		for (int j = 0; j < NL; j++) begin
			for (int a = 0; a < NA; a++) begin
				kcol[j][a]  = nlr_pkg::ColKW'(nlr_pkg::LampCol[light_set][j][a])
					* nlr_pkg::ColKW'(255);
				cprod[j][a] = CProdW'(kcol[j][a]) * CProdW'(mag_s2[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NL; j++) begin
			for (int a = 0; a < NA; a++) begin
				cont_s3[j][a] <= neg_s2[j] ? cprod[j][a][CProdW-1:32] : '0;
			end
		end
	end

	always_comb begin
		for (int a = 0; a < NA; a++) begin
			csum[a] = nlr_pkg::SumW'(cont_s3[0][a]) + nlr_pkg::SumW'(cont_s3[1][a])
				+ nlr_pkg::SumW'(cont_s3[2][a]);
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < NA; a++) begin
			sum_s4[a] <= csum[a];
		end
	end

	assign out_sum = '{vld: vld_s4, r: sum_s4[0], g: sum_s4[1], b: sum_s4[2]};

endmodule

// ===== hdl/nlr_pack.sv =====
// channel clamp, bias and rgb332 packing into the result registers
// depends on nlr_pkg
module nlr_pack (
	input  logic              clk,
	input  logic              arst_n,
	input  nlr_pkg::rgb_sum_t in_sum,
	output logic              done,
	output logic [7:0]        color_plain,
	output logic [7:0]        color_biased
);

	localparam int BW = nlr_pkg::SumW + 1;

	function automatic logic [7:0] sat8(input logic [BW-1:0] v);
		sat8 = (v > BW'(255)) ? 8'd255 : v[7:0];
	endfunction

	logic [7:0] r_p;
	logic [7:0] g_p;
	logic [7:0] b_p;
	logic [7:0] r_b;
	logic [7:0] g_b;
	logic [7:0] b_b;
	logic       done_q;
	logic [7:0] plain_q;
	logic [7:0] biased_q;

	assign r_p = sat8(BW'(in_sum.r));
	assign g_p = sat8(BW'(in_sum.g));
	assign b_p = sat8(BW'(in_sum.b));
	assign r_b = sat8(BW'(in_sum.r) + BW'(15));
	assign g_b = sat8(BW'(in_sum.g) + BW'(15));
	assign b_b = sat8(BW'(in_sum.b) + BW'(7));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_sum.vld;
		end
	end

	always_ff @(posedge clk) begin
		plain_q  <= {r_p[7:5], g_p[7:5], b_p[7:6]};
		biased_q <= {r_b[7:5], g_b[7:5], b_b[7:6]};
	end

	assign done         = done_q;
	assign color_plain  = plain_q;
	assign color_biased = biased_q;

endmodule

// ===== hdl/normal_lighting_rgb332_unit.sv =====
// top level of the normal lighting rgb332 unit: config registers and pipeline
// depends on nlr_pkg, nlr_rot, nlr_light, nlr_pack
//
// Usage:
//   A request is a signed Q2.16 surface normal on normal_x/y/z, taken at a rising
//   edge with start high and busy low. busy is always low: a new normal may
//   be given in every cycle, so throughput is one normal per clock.
//   The result shows on color_plain and color_biased for exactly one cycle,
//   marked by done, once the request has passed all the pipeline registers
//   (three two-stage rotations, four light stages, one packing stage).
//   Results leave in request order; the receiver cannot hold them off and
//   the pipeline never stalls.
//   Config: cfg_we, cfg_idx and cfg_data write roll/pitch/yaw sine and
//   cosine and the light set; writes take effect at once and must be done
//   while no request is in flight. Indexes past the light set are ignored.
//   Reset (arst_n low) empties the pipeline, drops requests in flight and
//   sets sines to 0, cosines to 1.0 and the light set to 0.
module normal_lighting_rgb332_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [nlr_pkg::TrigW-1:0] normal_x,
	input  logic signed [nlr_pkg::TrigW-1:0] normal_y,
	input  logic signed [nlr_pkg::TrigW-1:0] normal_z,
	output logic                           done,
	output logic [7:0]                     color_plain,
	output logic [7:0]                     color_biased,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_idx,
	input  logic [nlr_pkg::TrigW-1:0]      cfg_data
);

	logic [nlr_pkg::TrigW-1:0] roll_sin_q;
	logic [nlr_pkg::TrigW-1:0] roll_cos_q;
	logic [nlr_pkg::TrigW-1:0] pitch_sin_q;
	logic [nlr_pkg::TrigW-1:0] pitch_cos_q;
	logic [nlr_pkg::TrigW-1:0] yaw_sin_q;
	logic [nlr_pkg::TrigW-1:0] yaw_cos_q;
	logic [1:0]                light_set_q;

	nlr_pkg::trig_t     roll_trig;
	nlr_pkg::trig_t     pitch_trig;
	nlr_pkg::trig_t     yaw_trig;
	nlr_pkg::rot_item_t roll_in;
	nlr_pkg::rot_item_t roll_out;
	nlr_pkg::rot_item_t pitch_in;
	nlr_pkg::rot_item_t pitch_out;
	nlr_pkg::rot_item_t yaw_in;
	nlr_pkg::rot_item_t yaw_out;
	nlr_pkg::rot_item_t light_in;
	nlr_pkg::rgb_sum_t  sums;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_sin_q  <= '0;
			roll_cos_q  <= nlr_pkg::TrigOne;
			pitch_sin_q <= '0;
			pitch_cos_q <= nlr_pkg::TrigOne;
			yaw_sin_q   <= '0;
			yaw_cos_q   <= nlr_pkg::TrigOne;
			light_set_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				nlr_pkg::REG_ROLL_SIN: begin
					roll_sin_q <= cfg_data;
				end
				nlr_pkg::REG_ROLL_COS: begin
					roll_cos_q <= cfg_data;
				end
				nlr_pkg::REG_PITCH_SIN: begin
					pitch_sin_q <= cfg_data;
				end
				nlr_pkg::REG_PITCH_COS: begin
					pitch_cos_q <= cfg_data;
				end
				nlr_pkg::REG_YAW_SIN: begin
					yaw_sin_q <= cfg_data;
				end
				nlr_pkg::REG_YAW_COS: begin
					yaw_cos_q <= cfg_data;
				end
				nlr_pkg::REG_LIGHT_SET: begin
					light_set_q <= cfg_data[1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign busy = 1'b0;

	assign roll_trig  = '{s: roll_sin_q, c: roll_cos_q};
	assign pitch_trig = '{s: pitch_sin_q, c: pitch_cos_q};
	assign yaw_trig   = '{s: yaw_sin_q, c: yaw_cos_q};

	// roll rotates (x, y), z rides along
	assign roll_in = '{
		vld: start && !busy,
		u:   nlr_pkg::CompW'(normal_x),
		v:   nlr_pkg::CompW'(normal_y),
		w:   nlr_pkg::CompW'(normal_z)
	};

	nlr_rot u_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.trig     (roll_trig),
		.in_item  (roll_in),
		.out_item (roll_out)
	);

	// pitch rotates (y, z), x rides along
	assign pitch_in = '{vld: roll_out.vld, u: roll_out.v, v: roll_out.w, w: roll_out.u};

	nlr_rot u_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.trig     (pitch_trig),
		.in_item  (pitch_in),
		.out_item (pitch_out)
	);

	// yaw rotates (x, z), y rides along
	assign yaw_in = '{vld: pitch_out.vld, u: pitch_out.w, v: pitch_out.v, w: pitch_out.u};

	nlr_rot u_yaw (
		.clk      (clk),
		.arst_n   (arst_n),
		.trig     (yaw_trig),
		.in_item  (yaw_in),
		.out_item (yaw_out)
	);

	// back to x, y, z order
	assign light_in = '{vld: yaw_out.vld, u: yaw_out.u, v: yaw_out.w, w: yaw_out.v};

	nlr_light u_light (
		.clk       (clk),
		.arst_n    (arst_n),
		.light_set (light_set_q),
		.in_item   (light_in),
		.out_sum   (sums)
	);

	nlr_pack u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_sum       (sums),
		.done         (done),
		.color_plain  (color_plain),
		.color_biased (color_biased)
	);

endmodule

// ===== hdl/nlr_checker.sv =====
// port level checks for the normal lighting rgb332 unit, bound to the top
// depends on nlr_pkg and assert_macros.svh
`include "assert_macros.svh"

module nlr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [7:0] color_plain,
	input logic [7:0] color_biased
);

	logic r_step_ok;
	logic g_step_ok;
	logic b_step_ok;

	// bias moves each channel by at most one quantization step
	assign r_step_ok = (color_biased[7:5] == color_plain[7:5])
		|| (color_biased[7:5] == color_plain[7:5] + 3'd1);
	assign g_step_ok = (color_biased[4:2] == color_plain[4:2])
		|| (color_biased[4:2] == color_plain[4:2] + 3'd1);
	assign b_step_ok = (color_biased[1:0] == color_plain[1:0])
		|| (color_biased[1:0] == color_plain[1:0] + 2'd1);

	`ASSERT_NEVER(a_never_busy, clk, arst_n, busy)

	`ASSERT_IMPLY(a_req_gives_result, clk, arst_n, start && !busy, ##(nlr_pkg::Latency) done)

	`ASSERT_IMPLY(a_result_has_req, clk, arst_n, done, $past(start && arst_n, nlr_pkg::Latency))

	`ASSERT_IMPLY(a_bias_one_step, clk, arst_n, done, r_step_ok && g_step_ok && b_step_ok)

endmodule

bind normal_lighting_rgb332_unit nlr_checker u_nlr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.color_plain  (color_plain),
	.color_biased (color_biased)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// testbench for normal_lighting_rgb332_unit: directed and random normals under several
// angle and light set settings, each color pair checked in request order against a predictor
// depends on nlr_pkg and the unit's rtl
module testbench;

	typedef enum logic [1:0] {
		SET_NATURAL,
		SET_TWO_TONE,
		SET_RGB,
		SET_SPOOKY
	} light_set_e;

	typedef struct packed {
		logic [7:0] plain;
		logic [7:0] biased;
	} color_pair_t;

	localparam int FieldW = nlr_pkg::TrigW;
	localparam logic [2:0] RegUnused = 3'd7;
	localparam int Unit = 65536;
	localparam int FieldMin = -131072;
	localparam int FieldMax = 131071;
	localparam longint NegFull = -255 * 65536;
	localparam int StallLimit = 1000;
	localparam int Phases = 11;
	localparam int PhaseItems = 48;

	localparam int LampCount [4] = '{2, 3, 3, 1};

	localparam int DirTab [4][3][3] = '{
		'{ '{ 46340, 0, 46340 }, '{ -46340, 0, 46333 }, '{ 0, 0, 0 } },
		'{ '{ 0, 0, 65536 }, '{ 46340, 0, 46340 }, '{ -46340, 0, 46333 } },
		'{ '{ 0, -32768, 56754 }, '{ -46340, 0, 46333 }, '{ 46340, 0, 46340 } },
		'{ '{ 0, 46340, 46340 }, '{ 0, 0, 0 }, '{ 0, 0, 0 } }
	};

	localparam int ColTab [4][3][3] = '{
		'{ '{ 52428, 52428, 39321 }, '{ 39321, 39321, 52428 }, '{ 0, 0, 0 } },
		'{ '{ 6553, 6553, 6553 }, '{ 52428, 0, 13107 }, '{ 13107, 0, 65536 } },
		'{ '{ 65536, 0, 0 }, '{ 0, 49152, 0 }, '{ 0, 0, 65536 } },
		'{ '{ 16384, 6553, 65536 }, '{ 0, 0, 0 }, '{ 0, 0, 0 } }
	};

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [FieldW-1:0] normal_x = '0;
	logic signed [FieldW-1:0] normal_y = '0;
	logic signed [FieldW-1:0] normal_z = '0;
	logic done;
	logic [7:0] color_plain;
	logic [7:0] color_biased;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [FieldW-1:0] cfg_data = '0;

	logic signed [FieldW-1:0] trig_cfg [6];
	light_set_e set_cfg;
	color_pair_t color_queue [$];
	int errors = 0;
	int stall_cycles = 0;
	bit no_gaps = 1'b0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	normal_lighting_rgb332_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z),
		.done(done),
		.color_plain(color_plain),
		.color_biased(color_biased),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	function automatic longint qmul(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic logic [7:0] pack_rgb332(longint r, longint g, longint b);
		logic [7:0] r8, g8, b8;
		r8 = (r > 255) ? 8'd255 : r[7:0];
		g8 = (g > 255) ? 8'd255 : g[7:0];
		b8 = (b > 255) ? 8'd255 : b[7:0];
		return {r8[7:5], g8[7:5], b8[7:6]};
	endfunction

	function automatic color_pair_t light_normal(logic signed [FieldW-1:0] nx,
			logic signed [FieldW-1:0] ny, logic signed [FieldW-1:0] nz);
		longint x, y, z, t0, t1, m, r, g, b;
		longint rs, rc, ps, pc, ys, yc;
		int j;
		color_pair_t res;
		x = nx;
		y = ny;
		z = nz;
		rs = trig_cfg[nlr_pkg::REG_ROLL_SIN];
		rc = trig_cfg[nlr_pkg::REG_ROLL_COS];
		ps = trig_cfg[nlr_pkg::REG_PITCH_SIN];
		pc = trig_cfg[nlr_pkg::REG_PITCH_COS];
		ys = trig_cfg[nlr_pkg::REG_YAW_SIN];
		yc = trig_cfg[nlr_pkg::REG_YAW_COS];
		// roll about z, pitch about x, yaw about y
		t0 = qmul(rc, x) + qmul(-rs, y);
		t1 = qmul(rs, x) + qmul(rc, y);
		x = t0;
		y = t1;
		t0 = qmul(pc, y) + qmul(-ps, z);
		t1 = qmul(ps, y) + qmul(pc, z);
		y = t0;
		z = t1;
		t0 = qmul(yc, x) + qmul(-ys, z);
		t1 = qmul(ys, x) + qmul(yc, z);
		x = t0;
		z = t1;
		r = 0;
		g = 0;
		b = 0;
		for (j = 0; j < LampCount[set_cfg]; j++) begin
			m = qmul(x, DirTab[set_cfg][j][0]) + qmul(y, DirTab[set_cfg][j][1])
				+ qmul(z, DirTab[set_cfg][j][2]);
			if (m < 0) begin
				m = qmul(m, NegFull);
				r += qmul(ColTab[set_cfg][j][0], m) >>> 16;
				g += qmul(ColTab[set_cfg][j][1], m) >>> 16;
				b += qmul(ColTab[set_cfg][j][2], m) >>> 16;
			end
		end
		res.plain = pack_rgb332(r, g, b);
		res.biased = pack_rgb332(r + 15, g + 15, b + 7);
		return res;
	endfunction

	function automatic logic [FieldW-1:0] rand_trig();
		case ($urandom_range(0, 7))
			0: return FieldW'(Unit);
			1: return FieldW'(-Unit);
			2: return '0;
			3: return FieldW'($urandom);
			default: return FieldW'(int'($urandom_range(0, 2 * Unit)) - Unit);
		endcase
	endfunction

	function automatic logic [FieldW-1:0] rand_normal();
		case ($urandom_range(0, 9))
			0: return FieldW'(Unit);
			1: return FieldW'(-Unit);
			2: return FieldW'($urandom);
			default: return FieldW'(int'($urandom_range(0, 2 * Unit)) - Unit);
		endcase
	endfunction

	task automatic report_error(string msg);
		errors++;
		if (errors <= 100)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic send_normal(logic [FieldW-1:0] nx, logic [FieldW-1:0] ny,
			logic [FieldW-1:0] nz);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		normal_x <= nx;
		normal_y <= ny;
		normal_z <= nz;
		@(posedge clk);
		while (busy) @(posedge clk);
		color_queue.push_back(light_normal(nx, ny, nz));
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (color_queue.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [FieldW-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		if (idx < nlr_pkg::REG_LIGHT_SET)
			trig_cfg[idx] = val;
		else if (idx == nlr_pkg::REG_LIGHT_SET)
			set_cfg = light_set_e'(val[1:0]);
		@(posedge clk);
	endtask

	task automatic program_angles(logic [FieldW-1:0] rs, logic [FieldW-1:0] rc,
			logic [FieldW-1:0] ps, logic [FieldW-1:0] pc, logic [FieldW-1:0] ys,
			logic [FieldW-1:0] yc, light_set_e ls);
		write_reg(nlr_pkg::REG_ROLL_SIN, rs);
		write_reg(nlr_pkg::REG_ROLL_COS, rc);
		write_reg(nlr_pkg::REG_PITCH_SIN, ps);
		write_reg(nlr_pkg::REG_PITCH_COS, pc);
		write_reg(nlr_pkg::REG_YAW_SIN, ys);
		write_reg(nlr_pkg::REG_YAW_COS, yc);
		// upper data bits are don't care for the light set
		write_reg(nlr_pkg::REG_LIGHT_SET, {16'($urandom), ls});
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_normal('0, '0, '0);
		send_normal('0, '0, FieldW'(-Unit));
		send_normal(FieldW'(-Unit), '0, '0);
		send_normal(FieldW'(Unit), FieldW'(Unit), FieldW'(Unit));
		send_normal(FieldW'(FieldMin), FieldW'(FieldMin), FieldW'(FieldMin));
		send_normal(FieldW'(FieldMax), FieldW'(FieldMax), FieldW'(FieldMax));
		send_normal(FieldW'(FieldMin), '0, '0);
	endtask

	task automatic test_light_sets();
		for (int s = 0; s < 4; s++) begin
			wait_idle();
			write_reg(nlr_pkg::REG_LIGHT_SET, FieldW'(s));
			cfg_we <= 1'b0;
			send_normal('0, '0, FieldW'(-Unit));
			send_normal(FieldW'(-Unit), '0, FieldW'(-Unit));
			send_normal('0, FieldW'(-Unit), FieldW'(-Unit / 2));
		end
	endtask

	task automatic test_rotation_extremes();
		wait_idle();
		program_angles(FieldW'(Unit), '0, FieldW'(-Unit), '0, '0, FieldW'(-Unit),
			SET_NATURAL);
		send_normal(FieldW'(Unit), '0, '0);
		send_normal('0, FieldW'(-Unit), FieldW'(Unit));
		wait_idle();
		program_angles('0, FieldW'(-Unit), '0, FieldW'(-Unit), FieldW'(Unit), '0,
			SET_RGB);
		send_normal('0, '0, FieldW'(Unit));
		send_normal(FieldW'(-Unit), FieldW'(Unit), '0);
		// writes past the light set index must leave every register alone
		wait_idle();
		write_reg(RegUnused, '1);
		cfg_we <= 1'b0;
		send_normal('0, FieldW'(Unit), FieldW'(-Unit));
		send_normal(FieldW'(Unit), '0, FieldW'(Unit));
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < Phases; p++) begin
			wait_idle();
			program_angles(rand_trig(), rand_trig(), rand_trig(), rand_trig(), rand_trig(),
				rand_trig(), light_set_e'(p % 4));
			no_gaps = (p % 3 == 2);
			for (int i = 0; i < PhaseItems; i++) begin
				if ($urandom_range(0, 39) == 0)
					wait_idle();
				send_normal(rand_normal(), rand_normal(), rand_normal());
			end
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin
		color_pair_t want;
		if (!arst_n || (start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (arst_n && done) begin
			if (color_queue.size() == 0) begin
				report_error("result with no request pending");
			end else begin
				want = color_queue.pop_front();
				if (color_plain !== want.plain)
					report_error($sformatf("color_plain got %02h want %02h",
						color_plain, want.plain));
				if (color_biased !== want.biased)
					report_error($sformatf("color_biased got %02h want %02h",
						color_biased, want.biased));
			end
		end
	end

	initial begin
		while (stall_cycles < StallLimit) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin
		trig_cfg = '{0, Unit, 0, Unit, 0, Unit};
		set_cfg = SET_NATURAL;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_light_sets();
		test_rotation_extremes();
		test_random_phases();
		wait_idle();
		repeat (2 * nlr_pkg::Latency) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/nlr_pkg.sv
hdl/nlr_rot.sv
hdl/nlr_light.sv
hdl/nlr_pack.sv
hdl/normal_lighting_rgb332_unit.sv
hdl/nlr_checker.sv
sim/testbench.sv
